[rtl/irc_tok_pkg.sv]
// shared types and constants for the irc line tokenizer
`timescale 1ns / 1ps

package irc_tok_pkg;

    // sizing
    localparam int MAX_TOKENS   = 32;
    localparam int BUFFER_DEPTH = 8192;
    localparam int CNT_W        = $clog2(MAX_TOKENS);

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 14;
    localparam int ADDR_W  = 13;
    localparam int INDEX_W = 5;
    localparam int TOTAL_W = 6;

    localparam logic [POS_W-1:0] CAP_RESET = POS_W'(8192);
    localparam logic [POS_W-1:0] DEPTH_CAP = POS_W'(BUFFER_DEPTH);

    // special characters
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        KIND_STORE  = 3'd0,
        KIND_BREAK  = 3'd1,
        KIND_END    = 3'd2,
        KIND_FULL   = 3'd3,
        KIND_TOKENS = 3'd4,
        KIND_STREAM = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   wbyte;
        logic [INDEX_W-1:0]  tok_index;
        logic [TOTAL_W-1:0]  tok_total;
    } result_t;

endpackage

[rtl/irc_tok_core.sv]
// tokenizer state, capacity register and per-byte decision logic
`timescale 1ns / 1ps

module irc_tok_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_enable,
    input  logic [irc_tok_pkg::POS_W-1:0]      cfg_write_data,
    input  logic                               accept,
    input  logic [irc_tok_pkg::BYTE_W-1:0]     data_byte,
    input  logic                               stream_end,
    output irc_tok_pkg::result_t               result
);

    logic [irc_tok_pkg::POS_W-1:0]  cap_reg;
    logic [irc_tok_pkg::BYTE_W-1:0] prev_reg;
    logic [irc_tok_pkg::BYTE_W-1:0] prev_next;
    logic                           trail_reg;
    logic                           trail_next;
    logic [irc_tok_pkg::POS_W-1:0]  pos_reg;
    logic [irc_tok_pkg::POS_W-1:0]  pos_next;
    logic [irc_tok_pkg::CNT_W-1:0]  cnt_reg;
    logic [irc_tok_pkg::CNT_W-1:0]  cnt_next;

    logic [irc_tok_pkg::POS_W-1:0]  cap_eff;
    logic                           full;
    logic                           too_many;
    logic [irc_tok_pkg::POS_W-1:0]  end_pos;
    irc_tok_pkg::kind_t             kind;
    logic [irc_tok_pkg::POS_W-1:0]  addr_wide;
    logic [irc_tok_pkg::BYTE_W-1:0] wbyte;

    assign cap_eff  = (cap_reg > irc_tok_pkg::DEPTH_CAP) ? irc_tok_pkg::DEPTH_CAP : cap_reg;
    assign full     = (pos_reg >= cap_eff);
    assign too_many = ({1'b0, cnt_reg} + 1'b1) >= (irc_tok_pkg::CNT_W + 1)'(irc_tok_pkg::MAX_TOKENS);
    assign end_pos  = (pos_reg != '0) ? (pos_reg - 1'b1) : '0;

    // classify the byte
    always_comb
    begin
        kind      = irc_tok_pkg::KIND_STORE;
        addr_wide = pos_reg;
        wbyte     = '0;
        if (stream_end)
        begin
            kind = irc_tok_pkg::KIND_STREAM;
        end
        else if (data_byte == irc_tok_pkg::CH_LF && prev_reg == irc_tok_pkg::CH_CR)
        begin
            kind      = irc_tok_pkg::KIND_END;
            addr_wide = end_pos;
        end
        else if (full)
        begin
            kind = irc_tok_pkg::KIND_FULL;
        end
        else if (data_byte == irc_tok_pkg::CH_SPACE && !trail_reg)
        begin
            kind = too_many ? irc_tok_pkg::KIND_TOKENS : irc_tok_pkg::KIND_BREAK;
        end
        else
        begin
            kind  = irc_tok_pkg::KIND_STORE;
            wbyte = data_byte;
        end
    end

    // state update
    always_comb
    begin
        prev_next  = prev_reg;
        trail_next = trail_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            case (kind)
                irc_tok_pkg::KIND_STORE:
                begin
                    pos_next  = pos_reg + 1'b1;
                    prev_next = data_byte;
                    if (data_byte == irc_tok_pkg::CH_COLON && prev_reg == irc_tok_pkg::CH_SPACE)
                    begin
                        trail_next = 1'b1;
                    end
                end
                irc_tok_pkg::KIND_BREAK:
                begin
                    pos_next  = pos_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    prev_next = data_byte;
                end
                default:
                begin
                    prev_next  = '0;
                    trail_next = 1'b0;
                    pos_next   = '0;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= irc_tok_pkg::CAP_RESET;
            prev_reg  <= '0;
            trail_reg <= 1'b0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                cap_reg <= cfg_write_data;
            end
            prev_reg  <= prev_next;
            trail_reg <= trail_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign result.kind      = kind;
    assign result.addr      = addr_wide[irc_tok_pkg::ADDR_W-1:0];
    assign result.wbyte     = wbyte;
    assign result.tok_index = irc_tok_pkg::INDEX_W'(cnt_reg);
    assign result.tok_total = irc_tok_pkg::TOTAL_W'({1'b0, cnt_reg} + 1'b1);

    // restarting kinds clear the state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == irc_tok_pkg::KIND_END || kind == irc_tok_pkg::KIND_FULL ||
                   kind == irc_tok_pkg::KIND_TOKENS || kind == irc_tok_pkg::KIND_STREAM)
        |=> pos_reg == '0 && cnt_reg == '0 && !trail_reg)
        else $error("state not cleared after restart");

    // write position never runs past the usable buffer
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= irc_tok_pkg::DEPTH_CAP)
        else $error("write position beyond buffer depth");

    // a stored byte or break advances the position by one
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == irc_tok_pkg::KIND_STORE || kind == irc_tok_pkg::KIND_BREAK)
        |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("write position did not advance");

    // trailing mode is only entered by a colon
    a_trail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(trail_reg) |-> $past(data_byte) == irc_tok_pkg::CH_COLON)
        else $error("trailing mode entered without colon");

endmodule

[rtl/irc_tok_skid.sv]
// output register with one skid entry for the result channel
`timescale 1ns / 1ps

module irc_tok_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  irc_tok_pkg::result_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output irc_tok_pkg::result_t out_item
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    irc_tok_pkg::result_t out_item_reg;
    irc_tok_pkg::result_t out_item_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    irc_tok_pkg::result_t skid_item_reg;
    irc_tok_pkg::result_t skid_item_next;
    logic                 push;
    logic                 slot_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (slot_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_item_next   = skid_valid_reg ? skid_item_reg : in_item;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // skid entry only fills behind a held output
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item with empty output");

    // a stalled result with a new item fills the skid entry
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && push |=> skid_valid_reg)
        else $error("item lost behind stalled output");

    // skid entry drains into the output when taken
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry did not drain");

endmodule

[rtl/irc_line_tokenizer.sv]
// top level of the irc line tokenizer
`timescale 1ns / 1ps
// one byte per cycle while in_ready is high; each result is registered before it is offered
// the decision uses only the previous byte and small counters
// a one-entry skid stage lets one more byte in while a result waits to be taken
// reset: asynchronous, clears tokenizer state and both output slots; capacity returns to 8192
// no clearing pass: the block takes bytes as soon as reset is released

module irc_line_tokenizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: buffer capacity
    input  logic                                cfg_write_enable,
    input  logic [irc_tok_pkg::POS_W-1:0]       cfg_write_data,
    // input byte channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [irc_tok_pkg::BYTE_W-1:0]      data_byte,
    input  logic                                stream_end,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          result_kind,
    output logic [irc_tok_pkg::ADDR_W-1:0]      write_address,
    output logic [irc_tok_pkg::BYTE_W-1:0]      write_byte,
    output logic [irc_tok_pkg::INDEX_W-1:0]     token_index,
    output logic [irc_tok_pkg::TOTAL_W-1:0]     token_total
);

    logic                 accept;
    irc_tok_pkg::result_t core_result;
    irc_tok_pkg::result_t out_item;

    // an item moves the tokenizer state only when it is accepted
    assign accept = in_valid && in_ready;

    // decision logic and tokenizer state
    irc_tok_core u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .accept           (accept),
        .data_byte        (data_byte),
        .stream_end       (stream_end),
        .result           (core_result)
    );

    // result register plus skid entry
    irc_tok_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (core_result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // unpack the result item onto its ports
    assign result_kind   = out_item.kind;
    assign write_address = out_item.addr;
    assign write_byte    = out_item.wbyte;
    assign token_index   = out_item.tok_index;
    assign token_total   = out_item.tok_total;

endmodule

[sim/tb_irc_line_tokenizer.sv]
// self-checking testbench for the irc line tokenizer
`timescale 1ns / 1ps

module tb_irc_line_tokenizer;

    import irc_tok_pkg::*;

    // clock, reset and ports
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_enable;
    logic [POS_W-1:0]     cfg_write_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte;
    logic                 stream_end;
    logic                 out_valid;
    logic                 out_ready;
    logic [2:0]           result_kind;
    logic [ADDR_W-1:0]    write_address;
    logic [BYTE_W-1:0]    write_byte;
    logic [INDEX_W-1:0]   token_index;
    logic [TOTAL_W-1:0]   token_total;

    // tokenizer state as the testbench sees it
    logic [POS_W-1:0]     line_capacity;
    logic [BYTE_W-1:0]    last_byte;
    logic                 in_trailing;
    logic [POS_W-1:0]     line_pos;
    int                   tokens_so_far;

    // results still owed by the block, oldest first
    result_t              owed_results[$];

    int                   error_count;
    int                   bytes_sent;
    int                   results_seen;
    int                   cfg_writes;
    int                   kind_count[8];
    int                   hold_cycles;
    bit                   steady;

    irc_line_tokenizer u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .stream_end       (stream_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .write_address    (write_address),
        .write_byte       (write_byte),
        .token_index      (token_index),
        .token_total      (token_total)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("irc_line_tokenizer test failed");
        $finish;
    end

    // clear the line state, as on message end, on stream end and on every error
    function automatic void restart_line();
        last_byte     = '0;
        in_trailing   = 1'b0;
        line_pos      = '0;
        tokens_so_far = 0;
    endfunction

    // work out the result of one byte and advance the line state
    function automatic result_t tokenize_byte(input logic [BYTE_W-1:0] b, input logic eos);
        result_t          r;
        logic [POS_W-1:0] cap;
        logic             full;
        cap         = (line_capacity > DEPTH_CAP) ? DEPTH_CAP : line_capacity;
        full        = (line_pos >= cap);
        // token fields always reflect the counter before this byte
        r.tok_index = INDEX_W'(tokens_so_far);
        r.tok_total = TOTAL_W'(tokens_so_far + 1);
        r.addr      = line_pos[ADDR_W-1:0];
        r.wbyte     = '0;
        if (eos)
        begin
            r.kind = KIND_STREAM;
            restart_line();
        end
        else if (b == CH_LF && last_byte == CH_CR)
        begin
            // the stored cr becomes the terminating nul
            r.kind = KIND_END;
            r.addr = (line_pos > 0) ? ADDR_W'(line_pos - 1) : '0;
            restart_line();
        end
        else if (b == CH_SPACE && !in_trailing)
        begin
            if (full)
            begin
                r.kind = KIND_FULL;
                restart_line();
            end
            else if (tokens_so_far + 1 >= MAX_TOKENS)
            begin
                r.kind = KIND_TOKENS;
                restart_line();
            end
            else
            begin
                r.kind        = KIND_BREAK;
                tokens_so_far = tokens_so_far + 1;
                line_pos      = line_pos + 1'b1;
                last_byte     = b;
            end
        end
        else if (full)
        begin
            r.kind = KIND_FULL;
            restart_line();
        end
        else
        begin
            r.kind   = KIND_STORE;
            r.wbyte  = b;
            line_pos = line_pos + 1'b1;
            // colon opening a parameter switches to trailing text
            if (b == CH_COLON && last_byte == CH_SPACE)
                in_trailing = 1'b1;
            last_byte = b;
        end
        return r;
    endfunction

    // offer one item, hold it until taken, then log what it should produce
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos = 1'b0);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        stream_end <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        owed_results.push_back(tokenize_byte(b, eos));
        bytes_sent++;
    endtask

    // drop valid and wait until every owed result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (owed_results.size() == 0);
        repeat (3) @(negedge clk);
    endtask

    // capacity is only changed while the block is idle
    task automatic write_capacity(input logic [POS_W-1:0] value);
        drain();
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        line_capacity     = value;
        cfg_writes++;
    endtask

    // random parameter word; mostly printable, now and then any byte at all
    task automatic send_word();
        int len;
        len = $urandom_range(8, 1);
        repeat (len)
        begin
            if ($urandom_range(9) == 0)
                send_byte(BYTE_W'($urandom_range(255)));
            else
                send_byte(BYTE_W'($urandom_range(8'h7e, 8'h21)));
        end
    endtask

    // one protocol line: optional prefix, command, params, optional trailing text
    task automatic send_line(input int max_params);
        int n;
        int len;
        int ending;
        if ($urandom_range(3) == 0)
        begin
            send_byte(CH_COLON);
            send_word();
            send_byte(CH_SPACE);
        end
        send_word();
        n = $urandom_range(max_params);
        repeat (n)
        begin
            send_byte(CH_SPACE);
            send_word();
        end
        if ($urandom_range(1) == 1)
        begin
            send_byte(CH_SPACE);
            send_byte(CH_COLON);
            len = $urandom_range(20);
            repeat (len)
            begin
                if ($urandom_range(4) == 0)
                    send_byte(CH_SPACE);
                else
                    send_byte(BYTE_W'($urandom_range(8'h7e, 8'h21)));
            end
        end
        // mostly proper crlf, sometimes a broken or cut-off line
        ending = $urandom_range(9);
        if (ending == 1)
            send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        else if (ending == 2)
            send_byte(CH_CR);
        else if (ending > 2)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    // raw bytes with the special characters weighted up
    task automatic send_noise();
        int n;
        int pick;
        n = $urandom_range(10, 1);
        repeat (n)
        begin
            pick = $urandom_range(7);
            case (pick)
                0:       send_byte(CH_SPACE);
                1:       send_byte(CH_COLON);
                2:       send_byte(CH_CR);
                3:       send_byte(CH_LF);
                default: send_byte(BYTE_W'($urandom_range(255)));
            endcase
        end
    endtask

    // field extremes, store, break, end and stream results and the cr/lf and colon corner cases
    task automatic test_directed();
        send_byte(8'h4e);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CH_SPACE);
        send_byte(CH_SPACE);          // empty token
        send_byte(CH_COLON);          // colon after space opens trailing text
        send_byte(CH_SPACE);          // stored as a plain byte in trailing text
        send_byte(8'h78);
        send_byte(CH_LF);             // lone lf is just data
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);             // message end
        send_byte(CH_COLON);          // leading colon does not open trailing text
        send_byte(8'h61);
        send_byte(CH_SPACE);
        send_byte(8'h62);
        send_byte(CH_CR);
        send_byte(8'h63);             // cr not followed by lf
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hff, 1'b1);       // end of stream
        send_byte(CH_CR);
        send_byte(CH_LF, 1'b1);       // end of stream wins over a pending crlf
        send_byte(8'h7a);
        send_byte(8'h00, 1'b1);
    endtask

    // 31 breaks are fine, the next one overflows the token count
    task automatic test_token_limit();
        repeat (31)
        begin
            send_byte(8'h61);
            send_byte(CH_SPACE);
        end
        send_byte(CH_SPACE);
        // the same limit reached with empty tokens only
        repeat (31)
            send_byte(CH_SPACE);
        send_byte(CH_SPACE);
    endtask

    // small and out-of-range capacities, full buffer on stores and on breaks
    task automatic test_capacity();
        write_capacity(POS_W'(1));
        send_byte(8'h61);
        send_byte(8'h62);             // overflow on a store
        send_byte(CH_SPACE);
        send_byte(CH_SPACE);          // overflow on a break
        write_capacity(POS_W'(0));    // nothing fits at all
        send_byte(8'h61);
        send_byte(CH_SPACE);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h61, 1'b1);
        write_capacity(POS_W'(3));
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(CH_SPACE);
        send_byte(8'h63);
        send_byte(8'h61);
        send_byte(CH_CR);
        send_byte(CH_LF);             // end with the buffer just short of full
        // buffer and token limits hit by the same break: buffer wins
        write_capacity(POS_W'(31));
        repeat (32)
            send_byte(CH_SPACE);
        // above the physical depth the capacity is clamped
        write_capacity(POS_W'(16383));
        send_line(4);
        write_capacity(POS_W'(8192));
        send_line(4);
    endtask

    // receiver holds off for a long stretch while the sender keeps going
    task automatic test_backpressure();
        drain();
        steady      = 1'b1;
        hold_cycles = 300;
        repeat (40)
            send_byte(BYTE_W'($urandom_range(255)));
        steady = 1'b0;
    endtask

    // one random phase: mostly well-formed lines, some noise and cut-off input
    task automatic random_phase(input int count);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_line(6);
            else if (pick < 82)
                send_line(40);
            else if (pick < 95)
                send_noise();
            else
                send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic test_random();
        write_capacity(POS_W'(8192));
        steady = 1'b1;
        random_phase(150);
        steady = 1'b0;
        random_phase(400);
        write_capacity(POS_W'(48));
        random_phase(400);
        write_capacity(POS_W'(12));
        random_phase(350);
        write_capacity(POS_W'($urandom_range(8192, 1)));
        random_phase(250);
    endtask

    // receiver: random stalls, long hold-off when asked, none in steady stretches
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles  = hold_cycles - 1;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 33);
    end

    // compare every taken result with the oldest owed one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            kind_count[result_kind]++;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: kind %0d addr %0d", result_kind,
                       write_address);
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind expected %0d got %0d", want.kind, result_kind);
                    error_count++;
                end
                if (write_address !== want.addr)
                begin
                    $error("write_address expected %0d got %0d", want.addr, write_address);
                    error_count++;
                end
                if (write_byte !== want.wbyte)
                begin
                    $error("write_byte expected 0x%02h got 0x%02h", want.wbyte, write_byte);
                    error_count++;
                end
                if (token_index !== want.tok_index)
                begin
                    $error("token_index expected %0d got %0d", want.tok_index, token_index);
                    error_count++;
                end
                if (token_total !== want.tok_total)
                begin
                    $error("token_total expected %0d got %0d", want.tok_total, token_total);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        data_byte        = '0;
        stream_end       = 1'b0;
        out_ready        = 1'b0;
        error_count      = 0;
        bytes_sent       = 0;
        results_seen     = 0;
        cfg_writes       = 0;
        hold_cycles      = 0;
        steady           = 1'b0;
        line_capacity    = CAP_RESET;
        restart_line();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_token_limit();
        test_capacity();
        test_backpressure();
        test_random();

        // let the last results come back, then idle before the summary
        drain();
        repeat (10) @(negedge clk);

        $display("covered %0d bytes, %0d results, %0d capacity writes incl. 0, 1 and 16383",
                 bytes_sent, results_seen, cfg_writes);
        $display("results by kind: store %0d break %0d end %0d full %0d tokens %0d stream %0d",
                 kind_count[KIND_STORE], kind_count[KIND_BREAK], kind_count[KIND_END],
                 kind_count[KIND_FULL], kind_count[KIND_TOKENS], kind_count[KIND_STREAM]);
        if (error_count == 0)
            $display("irc_line_tokenizer test passed");
        else
            $display("irc_line_tokenizer test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/irc_tok_pkg.sv
rtl/irc_tok_core.sv
rtl/irc_tok_skid.sv
rtl/irc_line_tokenizer.sv
sim/tb_irc_line_tokenizer.sv
